### src/lav_pkg.sv
package lav_pkg;

  // Number formats
  localparam int COORD_W = 32;               // Q16.16 coordinate
  localparam int FRAC_W  = 16;               // fraction bits
  localparam int VEC_W   = COORD_W + 2;      // difference vector component
  localparam int UNIT_W  = FRAC_W + 2;       // unit component, |v| <= 1.0

  // Column sequencing
  localparam int NUM_COLS = 4;

  // Sideband widths of the two normalizer passes
  localparam int EYE_SB_W  = 3 * COORD_W;
  localparam int BASE_SB_W = EYE_SB_W + 3 * UNIT_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic [1:0]                col_idx_t;

  localparam col_idx_t COL_LAST  = col_idx_t'(NUM_COLS - 1);
  localparam coord_t   Q_ONE     = coord_t'(32'h0001_0000);
  localparam coord_t   COORD_MAX = coord_t'(32'h7FFF_FFFF);
  localparam coord_t   COORD_MIN = coord_t'(32'h8000_0000);

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t row0;
    coord_t row1;
    coord_t row2;
    coord_t row3;
  } column_t;

endpackage

### src/look_at_view_matrix.sv
// Right-handed look-at view matrix in Q16.16, up fixed at +Y. A request
// (eye, target) is taken when start is high and busy is low; busy then stays
// high, so that requests are spaced by the time the single result channel
// needs to send the four columns of a matrix, one per cycle. The time to
// column 0 is set mostly by the two normalizer pipelines (32-stage square
// root and 17-stage divider each); columns 1 to 3 follow on the next cycles,
// last_column marks column 3. out_valid is high once per column and
// cannot be held off by the receiver;
// results must be captured on the cycle they appear.
module look_at_view_matrix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lav_pkg::coord_t   in_eye_x,
  input  lav_pkg::coord_t   in_eye_y,
  input  lav_pkg::coord_t   in_eye_z,
  input  lav_pkg::coord_t   in_target_x,
  input  lav_pkg::coord_t   in_target_y,
  input  lav_pkg::coord_t   in_target_z,
  output logic              out_valid,
  output lav_pkg::col_idx_t out_column_index,
  output lav_pkg::coord_t   out_row0_value,
  output lav_pkg::coord_t   out_row1_value,
  output lav_pkg::coord_t   out_row2_value,
  output lav_pkg::coord_t   out_row3_value,
  output logic              out_last_column
);
  import lav_pkg::*;

  logic     accept;
  col_idx_t gap_r, gap_nxt;
  logic     in_vld_r;
  vec_t     diff_r [3];
  point_t   eye_r;

  logic                 f_vld;
  unit_t                f_u [3];
  logic [EYE_SB_W-1:0]  f_sb;
  vec_t                 s_in [3];
  logic [BASE_SB_W-1:0] s_sb_in;
  logic                 s_vld;
  unit_t                s_u [3];
  logic [BASE_SB_W-1:0] s_sb;
  unit_t                f_dly [3];
  point_t               eye_dly;
  logic                 b_vld;
  column_t              b_col [4];

  // request spacing: busy holds off new requests until the gap counter runs down
  assign accept = start && !busy;
  assign busy   = (gap_r != '0);

  always_comb begin
    if (accept)           gap_nxt = COL_LAST;
    else if (gap_r != '0) gap_nxt = gap_r - col_idx_t'(1);
    else                  gap_nxt = gap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r    <= '0;
      in_vld_r <= 1'b0;
    end else begin
      gap_r    <= gap_nxt;
      in_vld_r <= accept;
    end
  end

  // forward direction, exact in 33 bits
  always_ff @(posedge clk) begin
    diff_r[0] <= vec_t'(in_target_x) - vec_t'(in_eye_x);
    diff_r[1] <= vec_t'(in_target_y) - vec_t'(in_eye_y);
    diff_r[2] <= vec_t'(in_target_z) - vec_t'(in_eye_z);
    eye_r     <= '{x: in_eye_x, y: in_eye_y, z: in_eye_z};
  end

  lav_norm #(.SB_W(EYE_SB_W)) u_norm_f (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vld_r),
    .in_v      (diff_r),
    .in_sb     (eye_r),
    .out_valid (f_vld),
    .out_u     (f_u),
    .out_sb    (f_sb)
  );

  // side = forward x (0,1,0) = (-fz, 0, fx)
  assign s_in[0] = -vec_t'(f_u[2]);
  assign s_in[1] = '0;
  assign s_in[2] = vec_t'(f_u[0]);
  assign s_sb_in = {f_sb, f_u[0], f_u[1], f_u[2]};

  lav_norm #(.SB_W(BASE_SB_W)) u_norm_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_vld),
    .in_v      (s_in),
    .in_sb     (s_sb_in),
    .out_valid (s_vld),
    .out_u     (s_u),
    .out_sb    (s_sb)
  );

  assign f_dly[2] = s_sb[UNIT_W-1:0];
  assign f_dly[1] = s_sb[2*UNIT_W-1:UNIT_W];
  assign f_dly[0] = s_sb[3*UNIT_W-1:2*UNIT_W];
  assign eye_dly  = s_sb[BASE_SB_W-1:3*UNIT_W];

  lav_basis u_basis (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_vld),
    .in_s      (s_u),
    .in_f      (f_dly),
    .in_eye    (eye_dly),
    .out_valid (b_vld),
    .out_col   (b_col)
  );

  lav_colseq u_colseq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (b_vld),
    .in_col           (b_col),
    .out_valid        (out_valid),
    .out_column_index (out_column_index),
    .out_row0_value   (out_row0_value),
    .out_row1_value   (out_row1_value),
    .out_row2_value   (out_row2_value),
    .out_row3_value   (out_row3_value),
    .out_last_column  (out_last_column)
  );

endmodule

### src/lav_norm.sv
module lav_norm #(
  parameter int SB_W = lav_pkg::EYE_SB_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  lav_pkg::vec_t      in_v [3],
  input  logic [SB_W-1:0]    in_sb,
  output logic               out_valid,
  output lav_pkg::unit_t     out_u [3],
  output logic [SB_W-1:0]    out_sb
);
  import lav_pkg::*;

  localparam int MAG_W     = VEC_W - 1;          // component magnitude
  localparam int SH_W      = 31;                 // magnitude after prescale
  localparam int SQ_W      = 2 * SH_W;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int SQ_STEPS  = SUM_W / 2;
  localparam int QUO_W     = FRAC_W + 1;         // quotient up to 1.0
  localparam int NUM_W     = SH_W + FRAC_W + 1;
  localparam int DIV_STEPS = QUO_W;

  // stage A: magnitudes, prescale
  logic [MAG_W-1:0] mag [3];
  logic [MAG_W-1:0] mag_max;
  logic [1:0]       pre_sh;
  logic [SH_W-1:0]  a_m_r [3];
  logic             a_neg_r [3];
  logic [SB_W-1:0]  a_sb_r;
  logic             a_vld_r;

  // stage B: squares
  logic [SQ_W-1:0]  b_sq_r [3];
  logic [SH_W-1:0]  b_m_r [3];
  logic             b_neg_r [3];
  logic [SB_W-1:0]  b_sb_r;
  logic             b_vld_r;

  // square root pipe, one result bit per stage
  logic [SUM_W-1:0] sq_v_r   [SQ_STEPS+1];
  logic [SUM_W-1:0] sq_rt_r  [SQ_STEPS+1];
  logic [SH_W-1:0]  sq_m_r   [SQ_STEPS+1][3];
  logic             sq_neg_r [SQ_STEPS+1][3];
  logic [SB_W-1:0]  sq_sb_r  [SQ_STEPS+1];
  logic             sq_vld_r [SQ_STEPS+1];
  logic [SUM_W-1:0] sq_bit   [SQ_STEPS];
  logic [SUM_W:0]   sq_try   [SQ_STEPS];
  logic [SUM_W-1:0] sq_v_nxt  [SQ_STEPS];
  logic [SUM_W-1:0] sq_rt_nxt [SQ_STEPS];

  // divider pipe, one quotient bit per stage
  logic [ROOT_W-1:0] root;
  logic [NUM_W-1:0]  num [3];
  logic [ROOT_W-1:0] dv_rem_r  [DIV_STEPS+1][3];
  logic [QUO_W-1:0]  dv_low_r  [DIV_STEPS+1][3];
  logic [QUO_W-1:0]  dv_q_r    [DIV_STEPS+1][3];
  logic              dv_neg_r  [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] dv_len_r  [DIV_STEPS+1];
  logic              dv_zero_r [DIV_STEPS+1];
  logic [SB_W-1:0]   dv_sb_r   [DIV_STEPS+1];
  logic              dv_vld_r  [DIV_STEPS+1];
  logic [ROOT_W:0]   dv_try    [DIV_STEPS][3];
  logic              dv_ge     [DIV_STEPS][3];
  logic [ROOT_W-1:0] dv_rem_nxt [DIV_STEPS][3];

  logic              out_vld_r;
  unit_t             out_u_r [3];
  logic [SB_W-1:0]   out_sb_r;

  // magnitudes and the prescale shift that keeps them below 2^31
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = in_v[i][VEC_W-1] ? MAG_W'(-in_v[i]) : MAG_W'(in_v[i]);
    end
    mag_max = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > mag_max) mag_max = mag[2];
    if (mag_max[MAG_W-1])      pre_sh = 2'd2;
    else if (mag_max[MAG_W-2]) pre_sh = 2'd1;
    else                       pre_sh = 2'd0;
  end

  // square root step: test and subtract one bit pair
  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_bit[k] = SUM_W'(1) << (SUM_W - 2 - 2 * k);
      sq_try[k] = {1'b0, sq_rt_r[k]} + {1'b0, sq_bit[k]};
      if ({1'b0, sq_v_r[k]} >= sq_try[k]) begin
        sq_v_nxt[k]  = sq_v_r[k] - sq_try[k][SUM_W-1:0];
        sq_rt_nxt[k] = (sq_rt_r[k] >> 1) + sq_bit[k];
      end else begin
        sq_v_nxt[k]  = sq_v_r[k];
        sq_rt_nxt[k] = sq_rt_r[k] >> 1;
      end
    end
  end

  // rounded numerator m * 1.0 + L/2
  always_comb begin
    root = sq_rt_r[SQ_STEPS][ROOT_W-1:0];
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'({sq_m_r[SQ_STEPS][i], {FRAC_W{1'b0}}}) + NUM_W'(root >> 1);
    end
  end

  // restoring division step
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int i = 0; i < 3; i++) begin
        dv_try[k][i] = {dv_rem_r[k][i], dv_low_r[k][i][QUO_W-1]};
        dv_ge[k][i]  = dv_try[k][i] >= {1'b0, dv_len_r[k]};
        dv_rem_nxt[k][i] = dv_ge[k][i] ? ROOT_W'(dv_try[k][i] - {1'b0, dv_len_r[k]})
                                       : ROOT_W'(dv_try[k][i]);
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      for (int k = 0; k <= SQ_STEPS; k++) sq_vld_r[k] <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_vld_r[k] <= 1'b0;
    end else begin
      a_vld_r     <= in_valid;
      b_vld_r     <= a_vld_r;
      sq_vld_r[0] <= b_vld_r;
      for (int k = 0; k < SQ_STEPS; k++) sq_vld_r[k+1] <= sq_vld_r[k];
      dv_vld_r[0] <= sq_vld_r[SQ_STEPS];
      for (int k = 0; k < DIV_STEPS; k++) dv_vld_r[k+1] <= dv_vld_r[k];
      out_vld_r   <= dv_vld_r[DIV_STEPS];
    end
  end

  // data path
  always_ff @(posedge clk) begin
    a_sb_r <= in_sb;
    b_sb_r <= a_sb_r;
    for (int i = 0; i < 3; i++) begin
      a_m_r[i]   <= SH_W'(mag[i] >> pre_sh);
      a_neg_r[i] <= in_v[i][VEC_W-1];
      b_sq_r[i]  <= SQ_W'(a_m_r[i]) * SQ_W'(a_m_r[i]);
      b_m_r[i]   <= a_m_r[i];
      b_neg_r[i] <= a_neg_r[i];
    end

    sq_v_r[0]  <= SUM_W'(b_sq_r[0]) + SUM_W'(b_sq_r[1]) + SUM_W'(b_sq_r[2]);
    sq_rt_r[0] <= '0;
    sq_sb_r[0] <= b_sb_r;
    for (int i = 0; i < 3; i++) begin
      sq_m_r[0][i]   <= b_m_r[i];
      sq_neg_r[0][i] <= b_neg_r[i];
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_v_r[k+1]  <= sq_v_nxt[k];
      sq_rt_r[k+1] <= sq_rt_nxt[k];
      sq_sb_r[k+1] <= sq_sb_r[k];
      for (int i = 0; i < 3; i++) begin
        sq_m_r[k+1][i]   <= sq_m_r[k][i];
        sq_neg_r[k+1][i] <= sq_neg_r[k][i];
      end
    end

    dv_len_r[0]  <= root;
    dv_zero_r[0] <= (root == '0);
    dv_sb_r[0]   <= sq_sb_r[SQ_STEPS];
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= ROOT_W'(num[i][NUM_W-1:QUO_W]);
      dv_low_r[0][i] <= num[i][QUO_W-1:0];
      dv_q_r[0][i]   <= '0;
      dv_neg_r[0][i] <= sq_neg_r[SQ_STEPS][i];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_len_r[k+1]  <= dv_len_r[k];
      dv_zero_r[k+1] <= dv_zero_r[k];
      dv_sb_r[k+1]   <= dv_sb_r[k];
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[k+1][i] <= dv_rem_nxt[k][i];
        dv_low_r[k+1][i] <= {dv_low_r[k][i][QUO_W-2:0], 1'b0};
        dv_q_r[k+1][i]   <= {dv_q_r[k][i][QUO_W-2:0], dv_ge[k][i]};
        dv_neg_r[k+1][i] <= dv_neg_r[k][i];
      end
    end

    // zero length: the vector was zero, keep it
    out_sb_r <= dv_sb_r[DIV_STEPS];
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_r[DIV_STEPS])
        out_u_r[i] <= '0;
      else if (dv_neg_r[DIV_STEPS][i])
        out_u_r[i] <= unit_t'(-$signed({1'b0, dv_q_r[DIV_STEPS][i]}));
      else
        out_u_r[i] <= unit_t'({1'b0, dv_q_r[DIV_STEPS][i]});
    end
  end

  assign out_valid = out_vld_r;
  assign out_u     = out_u_r;
  assign out_sb    = out_sb_r;

endmodule

### src/lav_basis.sv
module lav_basis (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  lav_pkg::unit_t    in_s [3],
  input  lav_pkg::unit_t    in_f [3],
  input  lav_pkg::point_t   in_eye,
  output logic              out_valid,
  output lav_pkg::column_t  out_col [4]
);
  import lav_pkg::*;

  localparam int SF_W  = 2 * UNIT_W;
  localparam int U_W   = UNIT_W + 2;
  localparam int SE_W  = UNIT_W + COORD_W;
  localparam int UE_W  = U_W + COORD_W;
  localparam int ACC_W = UE_W + 4;
  localparam int T_W   = COORD_W + 8;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [T_W-1:0]   tr_t;
  typedef logic signed [U_W-1:0]   up_t;

  // round half toward plus infinity, drop the fraction
  function automatic acc_t rnd_q16(input acc_t v);
    acc_t t;
    t = v + acc_t'(1 <<< (FRAC_W - 1));
    return t >>> FRAC_W;
  endfunction

  function automatic coord_t sat_coord(input tr_t v);
    if (&v[T_W-1:COORD_W-1] || ~|v[T_W-1:COORD_W-1]) return v[COORD_W-1:0];
    return v[T_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

  coord_t eye_c [3];

  // P1: products of the basis vectors
  logic signed [SF_W-1:0] p1_sf_r [4];
  logic signed [SE_W-1:0] p1_se_r [3];
  logic signed [SE_W-1:0] p1_fe_r [3];
  unit_t                  p1_s_r [3];
  unit_t                  p1_f_r [3];
  coord_t                 p1_eye_r [3];
  logic                   p1_vld_r;

  // P2: up vector, side and forward translations
  up_t    p2_u_r [3];
  tr_t    p2_ts_r, p2_tf_r;
  unit_t  p2_s_r [3];
  unit_t  p2_f_r [3];
  coord_t p2_eye_r [3];
  logic   p2_vld_r;

  // P3: up vector dot eye products
  logic signed [UE_W-1:0] p3_ue_r [3];
  up_t    p3_u_r [3];
  tr_t    p3_ts_r, p3_tf_r;
  unit_t  p3_s_r [3];
  unit_t  p3_f_r [3];
  logic   p3_vld_r;

  // P4: up translation
  tr_t    p4_tu_r, p4_ts_r, p4_tf_r;
  up_t    p4_u_r [3];
  unit_t  p4_s_r [3];
  unit_t  p4_f_r [3];
  logic   p4_vld_r;

  column_t p5_col_r [4];
  logic    p5_vld_r;

  assign eye_c[0] = in_eye.x;
  assign eye_c[1] = in_eye.y;
  assign eye_c[2] = in_eye.z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= in_valid;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    // side y is always zero, so only four cross terms remain
    p1_sf_r[0] <= SF_W'(in_s[2]) * SF_W'(in_f[1]);
    p1_sf_r[1] <= SF_W'(in_s[2]) * SF_W'(in_f[0]);
    p1_sf_r[2] <= SF_W'(in_s[0]) * SF_W'(in_f[2]);
    p1_sf_r[3] <= SF_W'(in_s[0]) * SF_W'(in_f[1]);
    for (int i = 0; i < 3; i++) begin
      p1_se_r[i]  <= SE_W'(in_s[i]) * SE_W'(eye_c[i]);
      p1_fe_r[i]  <= SE_W'(in_f[i]) * SE_W'(eye_c[i]);
      p1_s_r[i]   <= in_s[i];
      p1_f_r[i]   <= in_f[i];
      p1_eye_r[i] <= eye_c[i];
    end

    p2_u_r[0] <= up_t'(rnd_q16(-acc_t'(p1_sf_r[0])));
    p2_u_r[1] <= up_t'(rnd_q16(acc_t'(p1_sf_r[1]) - acc_t'(p1_sf_r[2])));
    p2_u_r[2] <= up_t'(rnd_q16(acc_t'(p1_sf_r[3])));
    p2_ts_r   <= tr_t'(-rnd_q16(acc_t'(p1_se_r[0]) + acc_t'(p1_se_r[1])
                                + acc_t'(p1_se_r[2])));
    p2_tf_r   <= tr_t'(rnd_q16(acc_t'(p1_fe_r[0]) + acc_t'(p1_fe_r[1])
                               + acc_t'(p1_fe_r[2])));
    for (int i = 0; i < 3; i++) begin
      p2_s_r[i]   <= p1_s_r[i];
      p2_f_r[i]   <= p1_f_r[i];
      p2_eye_r[i] <= p1_eye_r[i];
    end

    p3_ts_r <= p2_ts_r;
    p3_tf_r <= p2_tf_r;
    for (int i = 0; i < 3; i++) begin
      p3_ue_r[i] <= UE_W'(p2_u_r[i]) * UE_W'(p2_eye_r[i]);
      p3_u_r[i]  <= p2_u_r[i];
      p3_s_r[i]  <= p2_s_r[i];
      p3_f_r[i]  <= p2_f_r[i];
    end

    p4_tu_r <= tr_t'(-rnd_q16(acc_t'(p3_ue_r[0]) + acc_t'(p3_ue_r[1])
                              + acc_t'(p3_ue_r[2])));
    p4_ts_r <= p3_ts_r;
    p4_tf_r <= p3_tf_r;
    for (int i = 0; i < 3; i++) begin
      p4_u_r[i] <= p3_u_r[i];
      p4_s_r[i] <= p3_s_r[i];
      p4_f_r[i] <= p3_f_r[i];
    end

    // rotation columns, then the saturated translation column
    for (int c = 0; c < 3; c++) begin
      p5_col_r[c].row0 <= coord_t'(p4_s_r[c]);
      p5_col_r[c].row1 <= coord_t'(p4_u_r[c]);
      p5_col_r[c].row2 <= coord_t'(-p4_f_r[c]);
      p5_col_r[c].row3 <= '0;
    end
    p5_col_r[3].row0 <= sat_coord(p4_ts_r);
    p5_col_r[3].row1 <= sat_coord(p4_tu_r);
    p5_col_r[3].row2 <= sat_coord(p4_tf_r);
    p5_col_r[3].row3 <= Q_ONE;
  end

  assign out_valid = p5_vld_r;
  assign out_col   = p5_col_r;

endmodule

### src/lav_colseq.sv
module lav_colseq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  lav_pkg::column_t   in_col [4],
  output logic               out_valid,
  output lav_pkg::col_idx_t  out_column_index,
  output lav_pkg::coord_t    out_row0_value,
  output lav_pkg::coord_t    out_row1_value,
  output lav_pkg::coord_t    out_row2_value,
  output lav_pkg::coord_t    out_row3_value,
  output logic               out_last_column
);
  import lav_pkg::*;

  column_t  bank_r [NUM_COLS];
  col_idx_t col_r;
  logic     act_r;
  logic     out_vld_r;
  col_idx_t out_idx_r;
  column_t  out_col_r;
  logic     out_last_r;

  // column counter; a new matrix restarts it as the old one ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      col_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= act_r;
      if (in_valid) begin
        act_r <= 1'b1;
        col_r <= '0;
      end else if (act_r) begin
        col_r <= col_r + col_idx_t'(1);
        if (col_r == COL_LAST) act_r <= 1'b0;
      end
    end
  end

  // matrix bank and output register
  always_ff @(posedge clk) begin
    if (in_valid) bank_r <= in_col;
    out_idx_r  <= col_r;
    out_col_r  <= bank_r[col_r];
    out_last_r <= (col_r == COL_LAST);
  end

  assign out_valid        = out_vld_r;
  assign out_column_index = out_idx_r;
  assign out_row0_value   = out_col_r.row0;
  assign out_row1_value   = out_col_r.row1;
  assign out_row2_value   = out_col_r.row2;
  assign out_row3_value   = out_col_r.row3;
  assign out_last_column  = out_last_r;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lav_pkg::*;

  localparam int LATENCY = 120;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  coord_t   in_eye_x, in_eye_y, in_eye_z;
  coord_t   in_target_x, in_target_y, in_target_z;
  logic     out_valid;
  col_idx_t out_column_index;
  coord_t   out_row0_value, out_row1_value, out_row2_value, out_row3_value;
  logic     out_last_column;

  typedef struct {
    col_idx_t idx;
    coord_t   r0, r1, r2, r3;
    logic     last;
  } view_col_t;

  typedef struct {
    coord_t ex, ey, ez, tx, ty, tz;
    logic   typed;     // expected column 3 translation given in the row
    coord_t c3r0, c3r1, c3r2;
  } view_req_t;

  view_col_t expected_cols[$];
  int        err_count;
  int        sender_idle_pct;

  look_at_view_matrix dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_eye_x(in_eye_x), .in_eye_y(in_eye_y), .in_eye_z(in_eye_z),
    .in_target_x(in_target_x), .in_target_y(in_target_y), .in_target_z(in_target_z),
    .out_valid(out_valid), .out_column_index(out_column_index),
    .out_row0_value(out_row0_value), .out_row1_value(out_row1_value),
    .out_row2_value(out_row2_value), .out_row3_value(out_row3_value),
    .out_last_column(out_last_column)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q32.32 back to Q16.16, round half up
  function automatic longint round_q16(longint v);
    longint t;
    t = v + 32768;
    if (t >= 0) return t >>> 16;
    return -longint'((longint'(-t) + 65535) >>> 16);
  endfunction

  function automatic coord_t clamp_q16(longint v);
    if (v > 64'sd2147483647) return COORD_MAX;
    if (v < -64'sd2147483648) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // Normalize in place; zero vector stays zero
  task automatic unitize(inout longint v[3]);
    longint unsigned m[3];
    longint unsigned mx, sum, len, q;
    int sh;
    mx = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
      if (m[i] > mx) mx = m[i];
    end
    while (sh < 8 && (mx >> sh) >= (64'd1 << 31)) sh++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> sh;
      sum += m[i] * m[i];
    end
    if (sum != 0) begin
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 65536 + len / 2) / len;
        v[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
  endtask

  // Compute the four view matrix columns for one request
  task automatic predict_view(input view_req_t rq);
    longint e[3], f[3], s[3], u[3], t[3];
    longint cm[4][4];
    view_col_t c;
    e[0] = rq.ex; e[1] = rq.ey; e[2] = rq.ez;
    f[0] = longint'(rq.tx) - e[0];
    f[1] = longint'(rq.ty) - e[1];
    f[2] = longint'(rq.tz) - e[2];
    unitize(f);
    s[0] = -f[2]; s[1] = 0; s[2] = f[0];
    unitize(s);
    u[0] = round_q16(s[1] * f[2] - s[2] * f[1]);
    u[1] = round_q16(s[2] * f[0] - s[0] * f[2]);
    u[2] = round_q16(s[0] * f[1] - s[1] * f[0]);
    t[0] = -round_q16(s[0] * e[0] + s[1] * e[1] + s[2] * e[2]);
    t[1] = -round_q16(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]);
    t[2] = round_q16(f[0] * e[0] + f[1] * e[1] + f[2] * e[2]);
    for (int k = 0; k < 3; k++) begin
      cm[k][0] = s[k]; cm[k][1] = u[k]; cm[k][2] = -f[k]; cm[k][3] = 0;
    end
    cm[3][0] = t[0]; cm[3][1] = t[1]; cm[3][2] = t[2]; cm[3][3] = Q_ONE;
    for (int k = 0; k < NUM_COLS; k++) begin
      c.idx  = col_idx_t'(k);
      c.r0   = clamp_q16(cm[k][0]);
      c.r1   = clamp_q16(cm[k][1]);
      c.r2   = clamp_q16(cm[k][2]);
      c.r3   = clamp_q16(cm[k][3]);
      c.last = (c.idx == COL_LAST);
      // typed rows: column 3 translation read straight from the table
      if (rq.typed && k == 3) begin
        if (c.r0 !== rq.c3r0 || c.r1 !== rq.c3r1 || c.r2 !== rq.c3r2)
          report_mismatch("table row disagrees with prediction", 0, 0);
        c.r0 = rq.c3r0; c.r1 = rq.c3r1; c.r2 = rq.c3r2;
      end
      expected_cols.push_back(c);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    view_col_t w;
    if (rst_n && out_valid) begin
      if (expected_cols.size() == 0) begin
        report_mismatch("unexpected column", out_column_index, 0);
      end else begin
        w = expected_cols.pop_front();
        if (out_column_index !== w.idx) report_mismatch("column_index", out_column_index, w.idx);
        if (out_row0_value !== w.r0) report_mismatch("row0", out_row0_value, w.r0);
        if (out_row1_value !== w.r1) report_mismatch("row1", out_row1_value, w.r1);
        if (out_row2_value !== w.r2) report_mismatch("row2", out_row2_value, w.r2);
        if (out_row3_value !== w.r3) report_mismatch("row3", out_row3_value, w.r3);
        if (out_last_column !== w.last) report_mismatch("last_column", out_last_column, w.last);
      end
    end
  end

  // Issue one request, with random idle before it
  task automatic send_request(input view_req_t rq);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    in_eye_x = rq.ex; in_eye_y = rq.ey; in_eye_z = rq.ez;
    in_target_x = rq.tx; in_target_y = rq.ty; in_target_z = rq.tz;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_view(rq);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 32'h0008_0000)) - coord_t'(32'h0004_0000);
      2: return ($urandom_range(1)) ? COORD_MAX : COORD_MIN;
      default: return coord_t'($urandom_range(0, 32'h0400_0000)) - coord_t'(32'h0200_0000);
    endcase
  endfunction

  initial begin
    view_req_t dir_tbl[$];
    view_req_t rq;
    int mode;
    err_count = 0;
    sender_idle_pct = 13;
    start = 1'b0;
    rst_n = 1'b0;
    {in_eye_x, in_eye_y, in_eye_z, in_target_x, in_target_y, in_target_z} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: eye at target (typed: zero translation), straight along Y,
    // axis views, extremes
    dir_tbl = '{
      '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
      '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
        32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1, 0, 0, 0},
      '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1, 0, 0, 0},
      '{0, 0, 0, 0, 32'h0005_0000, 0, 0, 0, 0, 0},
      '{0, 32'h0005_0000, 0, 0, COORD_MIN, 0, 0, 0, 0, 0},
      '{0, 0, 32'h0005_0000, 0, 0, 0, 0, 0, 0, 0},
      '{32'h0005_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0},
      '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, 0, 0},
      '{COORD_MAX, 0, COORD_MIN, 0, 0, 0, 0, 0, 0, 0},
      '{COORD_MIN, 0, 0, COORD_MAX, 0, 32'h0000_0001, 0, 0, 0, 0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 1, 1, 1, 0, 0, 0, 0}
    };
    foreach (dir_tbl[i]) send_request(dir_tbl[i]);

    // Random: three idling phases
    for (int n = 0; n < 100; n++) begin
      if (n == 33) sender_idle_pct = 87;
      if (n == 66) sender_idle_pct = 0;
      mode = $urandom_range(3);
      rq.ex = rand_coord(mode); rq.ey = rand_coord(mode); rq.ez = rand_coord(mode);
      rq.tx = rand_coord(mode); rq.ty = rand_coord(mode); rq.tz = rand_coord(mode);
      if ($urandom_range(15) == 0) {rq.tx, rq.tz} = {rq.ex, rq.ez};
      rq.typed = 1'b0;
      send_request(rq);
    end

    while (expected_cols.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### files.f
src/lav_pkg.sv
src/lav_norm.sv
src/lav_basis.sv
src/lav_colseq.sv
src/look_at_view_matrix.sv
verif/tb_top.sv
